### rtl/stse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stse_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int VAL_W       = 32;

   // Request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Search modes
   localparam logic [1:0] MODE_EXACT   = 2'd0;
   localparam logic [1:0] MODE_FIRST   = 2'd1;
   localparam logic [1:0] MODE_LAST    = 2'd2;
   localparam logic [1:0] MODE_ROTATED = 2'd3;

   typedef struct packed {
      logic                    req_type;
      logic [9:0]              entry_index;
      logic signed [VAL_W-1:0] entry_value;
      logic signed [VAL_W-1:0] search_key;
      logic [1:0]              search_mode;
   } req_type_type;

   typedef struct packed {
      logic             hit;
      logic [CNT_W-1:0] position;
   } rsp_type;

   // Table access from the search sequencer
   typedef struct packed {
      logic                    wr_en;
      logic [IDX_W-1:0]        wr_addr;
      logic signed [VAL_W-1:0] wr_data;
      logic [IDX_W-1:0]        rd_addr_a;
      logic [IDX_W-1:0]        rd_addr_b;
   } table_port_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_ROT_HI,
      ST_FINAL_CHECK,
      ST_FINISH
   } search_state_type;

endpackage

`default_nettype wire

### rtl/stse_table_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stse_table_ram (
   input  wire logic                            clock,
   input  wire stse_pkg::table_port_type        port,
   output logic signed [stse_pkg::VAL_W-1:0]    rd_data_a,
   output logic signed [stse_pkg::VAL_W-1:0]    rd_data_b
);
   import stse_pkg::*;

   logic signed [VAL_W-1:0] mem [TABLE_DEPTH];

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
   end

   // Registered read on two ports
   always_ff @(posedge clock) begin
      rd_data_a <= mem[port.rd_addr_a];
      rd_data_b <= mem[port.rd_addr_b];
   end

endmodule

`default_nettype wire

### rtl/stse_search_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module stse_search_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire stse_pkg::req_type_type          req_data,
   input  wire logic [stse_pkg::CNT_W-1:0]      entry_count,
   output stse_pkg::table_port_type             tbl,
   input  wire logic signed [stse_pkg::VAL_W-1:0] rd_data_a,
   input  wire logic signed [stse_pkg::VAL_W-1:0] rd_data_b,
   output logic                                 res_done,
   output stse_pkg::rsp_type                    res_data,
   input  wire logic                            res_take
);
   import stse_pkg::*;

   search_state_type        state_ff, state_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        e_ff, e_in;
   logic [IDX_W-1:0]        mid_ff, mid_in;
   logic signed [VAL_W-1:0] key_ff, key_in;
   logic [1:0]              mode_ff, mode_in;
   logic signed [VAL_W-1:0] vm_ff, vm_in;
   logic                    hit_ff, hit_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;

   logic                    step;
   logic [CNT_W-1:0]        step_lo;
   logic [CNT_W-1:0]        step_e;
   logic [CNT_W-1:0]        mid_w;
   logic [CNT_W-1:0]        mid_plus;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Search window and result
   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      e_ff    <= e_in;
      mid_ff  <= mid_in;
      key_ff  <= key_in;
      mode_ff <= mode_in;
      vm_ff   <= vm_in;
      hit_ff  <= hit_in;
      pos_ff  <= pos_in;
   end

   // The window is [lo, e); every mode probes mid = lo + (e - lo - 1) / 2.
   // Writes only land in idle and reads only run while busy, so the
   // table needs no forwarding.
   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      e_in     = e_ff;
      mid_in   = mid_ff;
      key_in   = key_ff;
      mode_in  = mode_ff;
      vm_in    = vm_ff;
      hit_in   = hit_ff;
      pos_in   = pos_ff;

      req_stall     = (state_ff != ST_IDLE);
      res_done      = 1'b0;
      tbl.wr_en     = 1'b0;
      tbl.wr_addr   = req_data.entry_index[IDX_W-1:0];
      tbl.wr_data   = req_data.entry_value;
      tbl.rd_addr_a = mid_ff;
      tbl.rd_addr_b = lo_ff[IDX_W-1:0];

      step     = 1'b0;
      step_lo  = lo_ff;
      step_e   = e_ff;
      mid_w    = '0;
      mid_plus = CNT_W'(mid_ff) + CNT_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.req_type == REQ_WRITE) begin
                  // Drop writes beyond the table
                  tbl.wr_en = (CNT_W'(req_data.entry_index) < CNT_W'(TABLE_DEPTH));
               end else begin
                  key_in  = req_data.search_key;
                  mode_in = req_data.search_mode;
                  step    = 1'b1;
                  step_lo = '0;
                  step_e  = entry_count;
               end
            end
         end
         ST_COMPARE: begin
            case (mode_ff)
               MODE_EXACT: begin
                  if (key_ff > rd_data_a) begin
                     step    = 1'b1;
                     step_lo = mid_plus;
                  end else if (key_ff < rd_data_a) begin
                     step   = 1'b1;
                     step_e = CNT_W'(mid_ff);
                  end else begin
                     hit_in   = 1'b1;
                     pos_in   = CNT_W'(mid_ff);
                     state_in = ST_FINISH;
                  end
               end
               MODE_FIRST: begin
                  step = 1'b1;
                  if (key_ff > rd_data_a) begin
                     step_lo = mid_plus;
                  end else begin
                     step_e = CNT_W'(mid_ff);
                  end
               end
               MODE_LAST: begin
                  step = 1'b1;
                  if (key_ff >= rd_data_a) begin
                     step_lo = mid_plus;
                  end else begin
                     step_e = CNT_W'(mid_ff);
                  end
               end
               default: begin
                  // Rotated: port A holds table[mid], port B table[lo]
                  if (key_ff == rd_data_a) begin
                     hit_in   = 1'b1;
                     pos_in   = CNT_W'(mid_ff);
                     state_in = ST_FINISH;
                  end else if (rd_data_a >= rd_data_b) begin
                     step = 1'b1;
                     if (key_ff >= rd_data_b && key_ff < rd_data_a) begin
                        step_e = CNT_W'(mid_ff);
                     end else begin
                        step_lo = mid_plus;
                     end
                  end else begin
                     // Right half is sorted: fetch table[hi]
                     vm_in         = rd_data_a;
                     mid_w         = e_ff - CNT_W'(1);
                     tbl.rd_addr_a = mid_w[IDX_W-1:0];
                     state_in      = ST_ROT_HI;
                  end
               end
            endcase
         end
         ST_ROT_HI: begin
            step = 1'b1;
            if (key_ff > vm_ff && key_ff <= rd_data_a) begin
               step_lo = mid_plus;
            end else begin
               step_e = CNT_W'(mid_ff);
            end
         end
         ST_FINAL_CHECK: begin
            if (rd_data_a == key_ff) begin
               hit_in = 1'b1;
               pos_in = CNT_W'(mid_ff);
            end else begin
               hit_in = 1'b0;
               pos_in = '0;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            res_done = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Launch the next probe, or close out the search
      if (step) begin
         lo_in = step_lo;
         e_in  = step_e;
         if (step_lo < step_e) begin
            mid_w         = step_lo + ((step_e - step_lo - CNT_W'(1)) >> 1);
            mid_in        = mid_w[IDX_W-1:0];
            tbl.rd_addr_a = mid_w[IDX_W-1:0];
            tbl.rd_addr_b = step_lo[IDX_W-1:0];
            state_in      = ST_COMPARE;
         end else begin
            hit_in   = 1'b0;
            pos_in   = '0;
            state_in = ST_FINISH;
            case (mode_in)
               MODE_EXACT: begin
                  pos_in = step_lo;
               end
               MODE_FIRST: begin
                  if (step_lo < entry_count) begin
                     mid_in        = step_lo[IDX_W-1:0];
                     tbl.rd_addr_a = step_lo[IDX_W-1:0];
                     state_in      = ST_FINAL_CHECK;
                  end
               end
               MODE_LAST: begin
                  if (step_lo != '0) begin
                     mid_w         = step_lo - CNT_W'(1);
                     mid_in        = mid_w[IDX_W-1:0];
                     tbl.rd_addr_a = mid_w[IDX_W-1:0];
                     state_in      = ST_FINAL_CHECK;
                  end
               end
               default: begin
                  pos_in = '0;
               end
            endcase
         end
      end

      res_data.hit      = hit_ff;
      res_data.position = pos_ff;
   end

`ifndef SYNTHESIS
   a_probe_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE) |-> (CNT_W'(mid_ff) >= lo_ff) && (CNT_W'(mid_ff) < e_ff))
      else $error("probe index outside search window");

   a_window_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE || state_ff == ST_ROT_HI) |->
         (lo_ff <= e_ff) && (e_ff <= entry_count))
      else $error("search window exceeds live entries");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_data.req_type == REQ_QUERY) |=>
         (state_ff != ST_IDLE))
      else $error("accepted query did not start");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !res_take) |=>
         (state_ff == ST_FINISH) && $stable(hit_ff) && $stable(pos_ff))
      else $error("pending result changed before handoff");
`endif

endmodule

`default_nettype wire

### rtl/sorted_table_search_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Write beat: stored at the accepting edge, one beat per cycle while no query is busy.
// Query beat: a search of at most floor(log2(n)) + 1 probes, with one final
// check in modes 1 and 2, and in mode 3 one upper-bound read per probe in the rotated half.
// The result passes through the output register, and the next beat is taken once the
// sequencer has handed the result over; a stalled result holds.
// Reset (synchronous, active high) clears the entry count, sequencer and output valid.
module sorted_table_search_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire stse_pkg::req_type_type        req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output stse_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [stse_pkg::CNT_W-1:0]    csr_wr_data
);
   import stse_pkg::*;

   logic [CNT_W-1:0]        entries_ff, entries_in;
   logic [CNT_W-1:0]        entry_count;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   table_port_type          tbl;
   logic signed [VAL_W-1:0] rd_data_a;
   logic signed [VAL_W-1:0] rd_data_b;
   logic                    res_done;
   rsp_type                 res_data;
   logic                    res_take;

   // Entry count register
   always_comb begin
      entries_in = csr_wr_en ? csr_wr_data : entries_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else begin
         entries_ff <= entries_in;
      end
   end

   // Saturate the count at the table depth
   always_comb begin
      entry_count = (entries_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entries_ff;
   end

   stse_table_ram u_table (
      .clock     (clock),
      .port      (tbl),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   stse_search_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .entry_count (entry_count),
      .tbl         (tbl),
      .rd_data_a   (rd_data_a),
      .rd_data_b   (rd_data_b),
      .res_done    (res_done),
      .res_data    (res_data),
      .res_take    (res_take)
   );

   // Output register: load when empty or the held beat is leaving
   always_comb begin
      res_take     = res_done && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
